[design/tcptr_pkg.sv]
// Package for the two-class periodic task release core.
// Holds the item structs, the register index codes, the reset rates and the sequencer states.
// No dependencies.
package tcptr_pkg;

  localparam int MAX_CONTROL    = 3;
  localparam int MAX_BACKGROUND = 5;
  localparam int TICK_WIDTH     = 32;
  localparam int RATE_W         = 16;
  localparam int CFG_IDX_W      = 3;

  // Register index codes: first control rate, first background rate
  localparam logic [CFG_IDX_W-1:0] CFG_CTL_RATE_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_RATE_0  = 3'd3;

  localparam logic [RATE_W-1:0] CTL_RATE_RESET [MAX_CONTROL] = '{16'd10, 16'd10, 16'd10};
  localparam logic [RATE_W-1:0] BG_RATE_RESET [MAX_BACKGROUND] =
    '{16'd5, 16'd20, 16'd20, 16'd10, 16'd100};

  typedef struct packed {
    logic [31:0] control_tick;
    logic [31:0] background_tick;
  } in_item_t;

  typedef struct packed {
    logic [2:0] control_fire_mask;
    logic       background_fired;
    logic [2:0] background_index;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CTL,
    ST_BG,
    ST_DONE
  } seq_state_e;

endpackage

[design/two_class_periodic_task_release_core.sv]
// Top level of the two-class periodic task release core.
// Depends on tcptr_pkg for item structs, register codes, reset rates and states.
//
//   port group   direction  handshake              payload
//   in_*         in         in_valid_i/in_ready_o  tcptr_pkg::in_item_t (two tick stamps)
//   out_*        out        out_valid_o/out_ready_i tcptr_pkg::out_item_t (fire mask, bg index)
//   cfg_*        in         cfg_we_i (no wait)     cfg_idx_i, cfg_data_i (rate registers)
//
// One pass runs from the accepting edge through ST_CTL, ST_BG and ST_DONE to the output register;
// the background scan covers k tasks, where k is 1..N_BACKGROUND (the scan stops at the first due
// background task). The next item is taken only once the sequencer is back in ST_IDLE. The pass
// is run by the single subtract-and-compare unit, which checks one task per cycle while the
// sequencer is in ST_CTL or ST_BG.
// Reset clears the last-release stamps to zero and loads the default rates.
// in_ready_o is high only while the sequencer is idle; a waiting result in the output
// register does not block the next item, but a finished pass holds until that register frees.
module two_class_periodic_task_release_core #(
  parameter int N_CONTROL    = tcptr_pkg::MAX_CONTROL,
  parameter int N_BACKGROUND = tcptr_pkg::MAX_BACKGROUND,
  parameter int TICK_WIDTH   = tcptr_pkg::TICK_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tcptr_pkg::in_item_t                in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tcptr_pkg::out_item_t               out_data_o,
  input  logic                               cfg_we_i,
  input  logic [tcptr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tcptr_pkg::RATE_W-1:0]       cfg_data_i
);

  localparam int RW    = tcptr_pkg::RATE_W;
  localparam int CW    = (N_CONTROL > 1) ? $clog2(N_CONTROL) : 1;
  localparam int BW    = (N_BACKGROUND > 1) ? $clog2(N_BACKGROUND) : 1;
  localparam int SW    = (CW > BW) ? CW : BW;
  localparam int CMP_W = (TICK_WIDTH > RW) ? TICK_WIDTH : RW;

  // Rate registers and last-release stamps, one entry per existing task
  logic [RW-1:0]         ctl_rate_q [N_CONTROL];
  logic [RW-1:0]         bg_rate_q  [N_BACKGROUND];
  logic [TICK_WIDTH-1:0] ctl_last_q [N_CONTROL];
  logic [TICK_WIDTH-1:0] bg_last_q  [N_BACKGROUND];

  // Pass context
  logic [TICK_WIDTH-1:0] ctl_tick_q;
  logic [TICK_WIDTH-1:0] bg_tick_q;
  logic [SW-1:0]         step_q;
  logic [N_CONTROL-1:0]  mask_q;
  logic                  bg_fired_q;
  logic [SW-1:0]         bg_idx_q;

  // Output register
  logic                  out_valid_q;
  tcptr_pkg::out_item_t  out_q;

  tcptr_pkg::seq_state_e state_q, state_d;

  // Shared subtract-and-compare unit
  logic [CW-1:0]         ctl_sel;
  logic [BW-1:0]         bg_sel;
  logic [TICK_WIDTH-1:0] now_w;
  logic [TICK_WIDTH-1:0] last_w;
  logic [RW-1:0]         rate_w;
  logic [TICK_WIDTH-1:0] elapsed_w;
  logic                  due_w;

  logic                  in_fire;
  logic                  ctl_last_step;
  logic                  bg_last_step;
  logic                  out_load;

  assign ctl_sel   = step_q[CW-1:0];
  assign bg_sel    = step_q[BW-1:0];
  assign now_w     = (state_q == tcptr_pkg::ST_CTL) ? ctl_tick_q : bg_tick_q;
  assign last_w    = (state_q == tcptr_pkg::ST_CTL) ? ctl_last_q[ctl_sel] : bg_last_q[bg_sel];
  assign rate_w    = (state_q == tcptr_pkg::ST_CTL) ? ctl_rate_q[ctl_sel] : bg_rate_q[bg_sel];
  // Difference wraps modulo 2^TICK_WIDTH by the width of the subtraction
  assign elapsed_w = now_w - last_w;
  assign due_w     = CMP_W'(elapsed_w) >= CMP_W'(rate_w);

  assign in_ready_o    = (state_q == tcptr_pkg::ST_IDLE);
  assign in_fire       = in_valid_i && in_ready_o;
  assign ctl_last_step = (step_q == SW'(N_CONTROL - 1));
  assign bg_last_step  = (step_q == SW'(N_BACKGROUND - 1));

  // Sequencer: advance through control tasks, then background tasks until one is due or the last is checked
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      tcptr_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = tcptr_pkg::ST_CTL;
        end
      end
      tcptr_pkg::ST_CTL: begin
        if (ctl_last_step) begin
          state_d = tcptr_pkg::ST_BG;
        end
      end
      tcptr_pkg::ST_BG: begin
        if (due_w || bg_last_step) begin
          state_d = tcptr_pkg::ST_DONE;
        end
      end
      tcptr_pkg::ST_DONE: begin
        // Hold the finished pass until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tcptr_pkg::ST_IDLE;
        end
      end
      default: state_d = tcptr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcptr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Rate registers: writes to indices of absent tasks or beyond the list drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_CONTROL; i++) begin
        ctl_rate_q[i] <= tcptr_pkg::CTL_RATE_RESET[i];
      end
      for (int i = 0; i < N_BACKGROUND; i++) begin
        bg_rate_q[i] <= tcptr_pkg::BG_RATE_RESET[i];
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < N_CONTROL; i++) begin
        if (cfg_idx_i == tcptr_pkg::CFG_CTL_RATE_0 + tcptr_pkg::CFG_IDX_W'(i)) begin
          ctl_rate_q[i] <= cfg_data_i;
        end
      end
      for (int i = 0; i < N_BACKGROUND; i++) begin
        if (cfg_idx_i == tcptr_pkg::CFG_BG_RATE_0 + tcptr_pkg::CFG_IDX_W'(i)) begin
          bg_rate_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Last-release stamps: record the pass tick for each released task
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_CONTROL; i++) begin
        ctl_last_q[i] <= '0;
      end
      for (int i = 0; i < N_BACKGROUND; i++) begin
        bg_last_q[i] <= '0;
      end
    end else begin
      if (state_q == tcptr_pkg::ST_CTL && due_w) begin
        ctl_last_q[ctl_sel] <= ctl_tick_q;
      end
      if (state_q == tcptr_pkg::ST_BG && due_w) begin
        bg_last_q[bg_sel] <= bg_tick_q;
      end
    end
  end

  // Pass context: tick stamps, step counter and accumulated result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_tick_q <= '0;
      bg_tick_q  <= '0;
      step_q     <= '0;
      mask_q     <= '0;
      bg_fired_q <= 1'b0;
      bg_idx_q   <= '0;
    end else begin
      unique case (state_q)
        tcptr_pkg::ST_IDLE: begin
          if (in_fire) begin
            ctl_tick_q <= in_data_i.control_tick[TICK_WIDTH-1:0];
            bg_tick_q  <= in_data_i.background_tick[TICK_WIDTH-1:0];
            step_q     <= '0;
            mask_q     <= '0;
            bg_fired_q <= 1'b0;
            bg_idx_q   <= '0;
          end
        end
        tcptr_pkg::ST_CTL: begin
          if (due_w) begin
            mask_q[ctl_sel] <= 1'b1;
          end
          step_q <= ctl_last_step ? '0 : step_q + SW'(1);
        end
        tcptr_pkg::ST_BG: begin
          if (due_w) begin
            bg_fired_q <= 1'b1;
            bg_idx_q   <= step_q;
          end else if (!bg_last_step) begin
            step_q <= step_q + SW'(1);
          end
        end
        tcptr_pkg::ST_DONE: begin
          step_q <= step_q;
        end
        default: step_q <= '0;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.control_fire_mask <= 3'(mask_q);
      out_q.background_fired  <= bg_fired_q;
      out_q.background_index  <= 3'(bg_idx_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
